FILE: hdl/bjp_pkg.sv
// bjp_pkg: shared constants and types for the balanced job partitioner
// used by bjp_cfg, bjp_range_prep, bjp_owner_div and balanced_job_partitioner_top
package bjp_pkg;

  localparam int JOB_WIDTH_DEF    = 24;
  localparam int WORKER_WIDTH_DEF = 16;

  // register file: two registers at byte addresses 0 and 4
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_JOB_TOTAL    = 1'b0;
  localparam logic REG_WORKER_TOTAL = 1'b1;

  typedef struct packed {
    logic busy;     // quotient/remainder of the setup being recomputed
    logic wr_now;   // register write completes at this edge
  } bjp_cfg_stat_t;

endpackage

FILE: hdl/bjp_cfg.sv
// bjp_cfg: register port, plus the iterative divider that derives the per-worker
// share (quotient, remainder, split point) from the two registers; uses bjp_pkg
module bjp_cfg #(
  parameter int JOB_WIDTH    = bjp_pkg::JOB_WIDTH_DEF,
  parameter int WORKER_WIDTH = bjp_pkg::WORKER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bjp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bjp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bjp_pkg::CFG_DATA_W-1:0] prdata,
  output logic [JOB_WIDTH-1:0]           job_total,
  output logic [WORKER_WIDTH-1:0]        worker_total,
  output logic [JOB_WIDTH-1:0]           share_q,
  output logic [WORKER_WIDTH-1:0]        share_r,
  output logic [JOB_WIDTH-1:0]           split,
  output bjp_pkg::bjp_cfg_stat_t         stat
);

  localparam int J  = JOB_WIDTH;
  localparam int W  = WORKER_WIDTH;
  localparam int CW = $clog2(J + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [J-1:0]  job_total_r;
  logic [W-1:0]  worker_total_r;
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [J-1:0]  dq_r, dq_nxt;      // dividend bits out the top, quotient bits in
  logic [W-1:0]  acc_r, acc_nxt;    // partial remainder
  logic [J-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [J-1:0]  split_r, split_nxt;
  logic          wr;
  logic          reg_idx;
  logic [W:0]    trial;
  logic          take;
  logic [W+J:0]  split_full;

  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_total_r    <= '0;
      worker_total_r <= W'(1);
    end else if (wr) begin
      case (reg_idx)
        bjp_pkg::REG_JOB_TOTAL:    job_total_r    <= pwdata[J-1:0];
        bjp_pkg::REG_WORKER_TOTAL: worker_total_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bjp_pkg::REG_JOB_TOTAL:    prdata = bjp_pkg::CFG_DATA_W'(job_total_r);
      bjp_pkg::REG_WORKER_TOTAL: prdata = bjp_pkg::CFG_DATA_W'(worker_total_r);
      default:                   prdata = '0;
    endcase
  end

  // one restoring step per cycle
  assign trial      = {acc_r, dq_r[J-1]};
  assign take       = trial >= {1'b0, worker_total_r};
  assign split_full = (W+J+1)'(r_r) * (W+J+1)'({1'b0, q_r} + (J+1)'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dq_nxt    = dq_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    split_nxt = split_r;
    if (wr) begin
      // any write restarts the derivation
      state_nxt = ST_DIV;
      cnt_nxt   = '0;
    end else begin
      case (state_r)
        ST_IDLE: ;
        ST_DIV: begin
          acc_nxt = take ? W'(trial - {1'b0, worker_total_r}) : trial[W-1:0];
          dq_nxt  = {dq_r[J-2:0], take};
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(J - 1)) begin
            q_nxt     = {dq_r[J-2:0], take};
            r_nxt     = take ? W'(trial - {1'b0, worker_total_r}) : trial[W-1:0];
            state_nxt = ST_MUL;
          end
        end
        ST_MUL: begin
          split_nxt = split_full[J-1:0];
          state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      q_r     <= '0;
      r_r     <= '0;
      split_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      q_r     <= q_nxt;
      r_r     <= r_nxt;
      split_r <= split_nxt;
    end
  end

  // dividend is loaded on the write of either register
  always_ff @(posedge clk) begin
    if (wr) begin
      dq_r  <= (reg_idx == bjp_pkg::REG_JOB_TOTAL) ? pwdata[J-1:0] : job_total_r;
      acc_r <= '0;
    end else begin
      dq_r  <= dq_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign job_total    = job_total_r;
  assign worker_total = worker_total_r;
  assign share_q      = q_r;
  assign share_r      = r_r;
  assign split        = split_r;
  assign stat.busy    = (state_r != ST_IDLE);
  assign stat.wr_now  = wr;

endmodule

FILE: hdl/bjp_range_prep.sv
// bjp_range_prep: first three pipeline stages; compares against the share, builds
// the owner division operands and works out the rank's job range; uses bjp_pkg widths
module bjp_range_prep #(
  parameter int JOB_WIDTH    = bjp_pkg::JOB_WIDTH_DEF,
  parameter int WORKER_WIDTH = bjp_pkg::WORKER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_fire,
  input  logic [WORKER_WIDTH-1:0] rank,
  input  logic [JOB_WIDTH-1:0]    job,
  input  logic [JOB_WIDTH-1:0]    job_total,
  input  logic [WORKER_WIDTH-1:0] worker_total,
  input  logic [JOB_WIDTH-1:0]    share_q,
  input  logic [WORKER_WIDTH-1:0] share_r,
  input  logic [JOB_WIDTH-1:0]    split,
  output logic                    c_valid,
  output logic [JOB_WIDTH-1:0]    c_dividend,
  output logic [JOB_WIDTH:0]      c_divisor,
  output logic [WORKER_WIDTH-1:0] c_offset,
  output logic                    c_found,
  output logic                    c_range_valid,
  output logic [JOB_WIDTH-1:0]    c_first,
  output logic [JOB_WIDTH:0]      c_last,
  output logic [JOB_WIDTH-1:0]    c_count
);

  localparam int J  = JOB_WIDTH;
  localparam int W  = WORKER_WIDTH;
  localparam int MW = (J > W) ? J : W;

  logic [J:0]   qp1;
  logic         below;

  logic         a_v_r, b_v_r, c_v_r;
  logic [W-1:0] a_rank_r;
  logic         a_lt_r, a_rv_r, a_found_r;
  logic [J-1:0] a_dividend_r;
  logic [J:0]   a_divisor_r;
  logic [W-1:0] a_offset_r;

  logic [J:0]     mult_sel;
  logic [W+J:0]   prod_full;
  logic [J-1:0]   b_prod_r, b_count_r;
  logic           b_lt_r, b_rv_r, b_found_r;
  logic [J-1:0]   b_dividend_r;
  logic [J:0]     b_divisor_r;
  logic [W-1:0]   b_offset_r;

  logic [J-1:0] first_nxt, count_nxt;
  logic [J-1:0] c_first_r, c_count_r, c_dividend_r;
  logic [J:0]   c_last_r, c_divisor_r;
  logic         c_rv_r, c_found_r;
  logic [W-1:0] c_offset_r;

  assign qp1   = {1'b0, share_q} + (J+1)'(1);
  assign below = job < split;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_fire;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // stage a: compares and division operands
  always_ff @(posedge clk) begin
    if (adv) begin
      a_rank_r     <= rank;
      a_lt_r       <= MW'(rank) < MW'(share_r);
      a_rv_r       <= rank < worker_total;
      a_found_r    <= (job < job_total) && (worker_total != '0);
      a_dividend_r <= below ? job : job - split;
      a_divisor_r  <= below ? qp1 : {1'b0, share_q};
      a_offset_r   <= below ? '0 : share_r;
    end
  end

  // stage b: rank times per-worker share
  assign mult_sel  = a_lt_r ? qp1 : {1'b0, share_q};
  assign prod_full = (W+J+1)'(a_rank_r) * (W+J+1)'(mult_sel);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_prod_r     <= prod_full[J-1:0];
      b_count_r    <= mult_sel[J-1:0];
      b_lt_r       <= a_lt_r;
      b_rv_r       <= a_rv_r;
      b_found_r    <= a_found_r;
      b_dividend_r <= a_dividend_r;
      b_divisor_r  <= a_divisor_r;
      b_offset_r   <= a_offset_r;
    end
  end

  // stage c: short workers start after the remainder
  assign first_nxt = b_rv_r ? (b_prod_r + (b_lt_r ? '0 : J'(share_r))) : '0;
  assign count_nxt = b_rv_r ? b_count_r : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_first_r    <= first_nxt;
      c_count_r    <= count_nxt;
      c_last_r     <= {1'b0, first_nxt} + {1'b0, count_nxt} - (J+1)'(1);
      c_rv_r       <= b_rv_r;
      c_found_r    <= b_found_r;
      c_dividend_r <= b_dividend_r;
      c_divisor_r  <= b_divisor_r;
      c_offset_r   <= b_offset_r;
    end
  end

  assign c_valid       = c_v_r;
  assign c_dividend    = c_dividend_r;
  assign c_divisor     = c_divisor_r;
  assign c_offset      = c_offset_r;
  assign c_found       = c_found_r;
  assign c_range_valid = c_rv_r;
  assign c_first       = c_first_r;
  assign c_last        = c_last_r;
  assign c_count       = c_count_r;

endmodule

FILE: hdl/bjp_owner_div.sv
// bjp_owner_div: pipelined restoring divider, one quotient bit per stage, that
// carries a sideband word alongside; widths from bjp_pkg defaults
module bjp_owner_div #(
  parameter int JOB_WIDTH    = bjp_pkg::JOB_WIDTH_DEF,
  parameter int WORKER_WIDTH = bjp_pkg::WORKER_WIDTH_DEF,
  parameter int SIDE_W       = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_v,
  input  logic [JOB_WIDTH-1:0]    dividend,
  input  logic [JOB_WIDTH:0]      divisor,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    out_v,
  output logic [WORKER_WIDTH-1:0] quotient,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int J = JOB_WIDTH;
  localparam int W = WORKER_WIDTH;

  logic              v_r    [W];
  logic [J-1:0]      rem_r  [W];
  logic [J:0]        d_r    [W];
  logic [W-1:0]      quo_r  [W];
  logic [SIDE_W-1:0] side_r [W];

  genvar s;
  generate
    for (s = 0; s < W; s++) begin : g_stage
      localparam int B = W - 1 - s;   // quotient bit resolved here
      logic              v_i;
      logic [J-1:0]      rem_i;
      logic [J:0]        d_i;
      logic [W-1:0]      quo_i;
      logic [SIDE_W-1:0] side_i;
      logic              take;
      logic [J+W:0]      d_sh;

      if (s == 0) begin : g_first
        assign v_i    = in_v;
        assign rem_i  = dividend;
        assign d_i    = divisor;
        assign quo_i  = '0;
        assign side_i = side_in;
      end else begin : g_next
        assign v_i    = v_r[s-1];
        assign rem_i  = rem_r[s-1];
        assign d_i    = d_r[s-1];
        assign quo_i  = quo_r[s-1];
        assign side_i = side_r[s-1];
      end

      assign take = (J+1)'(rem_i >> B) >= d_i;
      assign d_sh = (J+W+1)'(d_i) << B;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (adv) begin
          v_r[s] <= v_i;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s]  <= take ? rem_i - d_sh[J-1:0] : rem_i;
          d_r[s]    <= d_i;
          quo_r[s]  <= quo_i | (take ? (W'(1) << B) : '0);
          side_r[s] <= side_i;
        end
      end
    end
  endgenerate

  assign out_v    = v_r[W-1];
  assign quotient = quo_r[W-1];
  assign side_out = side_r[W-1];

endmodule

FILE: hdl/balanced_job_partitioner_top.sv
// balanced_job_partitioner_top: splits job_total jobs over worker_total workers
// channels:  in_ (worker_rank, job_index) and out_ (range and owner), valid/ready;
//            cfg_ register port, job_total at 0x0 and worker_total at 0x4
// one word in gives one word out: the job range of the rank and the owner of the job
// pipeline:  stages a, b, c, the owner divider stages, then the output register
// throughput: one word per cycle when not stalled or rebuilding; the owner division
// is one quotient bit per stage; after a register write the quotient and remainder
// are rebuilt serially, one bit a cycle, and in_ready stays low meanwhile
// reset: job_total 0, worker_total 1, pipeline empty, ready right after reset
// stall: while out_valid waits for out_ready the whole pipeline holds; the output
// register still lets one more word in when it is empty or being drained
module balanced_job_partitioner_top #(
  parameter int JOB_WIDTH    = bjp_pkg::JOB_WIDTH_DEF,
  parameter int WORKER_WIDTH = bjp_pkg::WORKER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [WORKER_WIDTH-1:0]        in_worker_rank,
  input  logic [JOB_WIDTH-1:0]           in_job_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_range_valid,
  output logic [JOB_WIDTH-1:0]           out_first_job,
  output logic signed [JOB_WIDTH:0]      out_last_job,
  output logic [JOB_WIDTH-1:0]           out_job_count,
  output logic                           out_group_found,
  output logic [WORKER_WIDTH-1:0]        out_owner_rank,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bjp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bjp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bjp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int J      = JOB_WIDTH;
  localparam int W      = WORKER_WIDTH;
  localparam int SIDE_W = J + (J + 1) + J + 1 + 1 + W;

  bjp_pkg::bjp_cfg_stat_t cfg_stat;

  logic [J-1:0]      job_total, share_q, split;
  logic [W-1:0]      worker_total, share_r;
  logic              adv, in_fire;

  logic              c_valid, c_found, c_rv;
  logic [J-1:0]      c_dividend, c_first, c_count;
  logic [J:0]        c_divisor, c_last;
  logic [W-1:0]      c_offset;

  logic [SIDE_W-1:0] side_in, side_out;
  logic              d_valid;
  logic [W-1:0]      d_quo;

  logic [J-1:0]      s_first, s_count;
  logic [J:0]        s_last;
  logic              s_rv, s_found;
  logic [W-1:0]      s_offset;

  logic              out_valid_r;
  logic              rv_r, found_r;
  logic [J-1:0]      first_r, count_r;
  logic [J:0]        last_r;
  logic [W-1:0]      owner_r;

  assign cfg_pready = 1'b1;

  bjp_cfg #(.JOB_WIDTH(J), .WORKER_WIDTH(W)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .job_total    (job_total),
    .worker_total (worker_total),
    .share_q      (share_q),
    .share_r      (share_r),
    .split        (split),
    .stat         (cfg_stat)
  );

  // the whole pipeline moves when the output register can take a word
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !cfg_stat.busy && !cfg_stat.wr_now;
  assign in_fire  = in_valid && in_ready;

  bjp_range_prep #(.JOB_WIDTH(J), .WORKER_WIDTH(W)) u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_fire       (in_fire),
    .rank          (in_worker_rank),
    .job           (in_job_index),
    .job_total     (job_total),
    .worker_total  (worker_total),
    .share_q       (share_q),
    .share_r       (share_r),
    .split         (split),
    .c_valid       (c_valid),
    .c_dividend    (c_dividend),
    .c_divisor     (c_divisor),
    .c_offset      (c_offset),
    .c_found       (c_found),
    .c_range_valid (c_rv),
    .c_first       (c_first),
    .c_last        (c_last),
    .c_count       (c_count)
  );

  assign side_in = {c_first, c_last, c_count, c_rv, c_found, c_offset};

  bjp_owner_div #(.JOB_WIDTH(J), .WORKER_WIDTH(W), .SIDE_W(SIDE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (c_valid),
    .dividend (c_dividend),
    .divisor  (c_divisor),
    .side_in  (side_in),
    .out_v    (d_valid),
    .quotient (d_quo),
    .side_out (side_out)
  );

  assign {s_first, s_last, s_count, s_rv, s_found, s_offset} = side_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  // long workers own the jobs below the split, short ones follow from the remainder
  always_ff @(posedge clk) begin
    if (adv && d_valid) begin
      rv_r    <= s_rv;
      first_r <= s_first;
      last_r  <= s_last;
      count_r <= s_count;
      found_r <= s_found;
      owner_r <= s_found ? W'(s_offset + d_quo) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_valid = rv_r;
  assign out_first_job   = first_r;
  assign out_last_job    = $signed(last_r);
  assign out_job_count   = count_r;
  assign out_group_found = found_r;
  assign out_owner_rank  = owner_r;

`ifndef SYNTHESIS
  a_no_accept_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_stat.busy |-> !in_ready)
    else $error("word accepted while the share is being recomputed");

  a_owner_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group_found) |-> (out_owner_rank < worker_total))
    else $error("owner rank not below worker total");

  a_invalid_rank_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_valid) |->
      (out_first_job == '0 && out_job_count == '0 && out_last_job == -1))
    else $error("invalid rank gives a nonempty range");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(d_valid) && $stable(c_valid))
    else $error("pipeline moved during an output stall");
`endif

endmodule

FILE: dv/balanced_job_partitioner_top_test.sv
`timescale 1ns / 100ps
// balanced_job_partitioner_top_test: self-checking bench for the job partitioner top,
// streams rank/job queries through several register setups, checks each result word
// depends on bjp_pkg and balanced_job_partitioner_top
module balanced_job_partitioner_top_test;

  localparam int JW = bjp_pkg::JOB_WIDTH_DEF;
  localparam int WW = bjp_pkg::WORKER_WIDTH_DEF;
  localparam int PIPE_LATENCY = WW + 4;
  localparam bit [JW-1:0] JOB_MAX = '1;
  localparam bit [WW-1:0] RANK_MAX = '1;

  typedef struct packed {
    logic              range_valid;
    logic [JW-1:0]     first_job;
    logic signed [JW:0] last_job;
    logic [JW-1:0]     job_count;
    logic              group_found;
    logic [WW-1:0]     owner_rank;
  } job_share_t;

  typedef struct {
    bit [WW-1:0] rank;
    bit [JW-1:0] job;
  } share_query_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WW-1:0] in_worker_rank = '0;
  logic [JW-1:0] in_job_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_range_valid;
  logic [JW-1:0] out_first_job;
  logic signed [JW:0] out_last_job;
  logic [JW-1:0] out_job_count;
  logic out_group_found;
  logic [WW-1:0] out_owner_rank;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [bjp_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [bjp_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [bjp_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // local copy of the register settings
  bit [JW-1:0] job_cfg = '0;
  bit [WW-1:0] worker_cfg = 1;

  share_query_t query_q[$];
  job_share_t share_due_q[$];
  int unsigned queries_issued = 0;
  int unsigned queries_taken = 0;
  int unsigned err_count = 0;

  balanced_job_partitioner_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_worker_rank (in_worker_rank),
    .in_job_index   (in_job_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_range_valid(out_range_valid),
    .out_first_job  (out_first_job),
    .out_last_job   (out_last_job),
    .out_job_count  (out_job_count),
    .out_group_found(out_group_found),
    .out_owner_rank (out_owner_rank),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial forever #2 clk = ~clk;

  function automatic job_share_t predict_share(bit [JW-1:0] jobs, bit [WW-1:0] workers,
                                               bit [WW-1:0] rank, bit [JW-1:0] job);
    job_share_t s;
    bit [63:0] nj, nw, nr, nb, quo, rem, split, first, count, owner, last;
    s = '0;
    nj = 64'(jobs);
    nw = 64'(workers);
    nr = 64'(rank);
    nb = 64'(job);
    first = 0;
    count = 0;
    owner = 0;
    if (nw != 0) begin
      quo = nj / nw;
      rem = nj % nw;
      split = rem * (quo + 64'd1);
      if (nr < nw) begin
        s.range_valid = 1'b1;
        if (nr < rem) begin
          first = nr * (quo + 64'd1);
          count = quo + 64'd1;
        end else begin
          first = nr * quo + rem;
          count = quo;
        end
      end
      if (nb < nj) begin
        s.group_found = 1'b1;
        if (nb < split) begin
          owner = nb / (quo + 64'd1);
        end else if (quo != 0) begin
          owner = rem + (nb - split) / quo;
        end
      end
    end
    // empty or invalid range ends one below its start
    last = first + count - 64'd1;
    s.first_job = first[JW-1:0];
    s.last_job = last[JW:0];
    s.job_count = count[JW-1:0];
    s.owner_rank = owner[WW-1:0];
    return s;
  endfunction

  // driver: bursts of words with random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    share_query_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        share_due_q.insert(share_due_q.size(),
                           predict_share(job_cfg, worker_cfg, in_worker_rank,
                                         in_job_index));
        queries_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (query_q.size() > 0) begin
          nxt = query_q.pop_front();
          in_valid <= 1'b1;
          in_worker_rank <= nxt.rank;
          in_job_index <= nxt.job;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls follow a rotating pattern, reloaded as the pattern index wraps
  bit [31:0] stall_pat = '1;
  bit [4:0] pat_idx = '0;
  always @(posedge clk) begin
    job_share_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.range_valid = out_range_valid;
        got.first_job = out_first_job;
        got.last_job = out_last_job;
        got.job_count = out_job_count;
        got.group_found = out_group_found;
        got.owner_rank = out_owner_rank;
        if (share_due_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("error: result word with nothing pending, at %0t", $realtime);
        end else begin
          want = share_due_q.pop_front();
          if (got.range_valid !== want.range_valid || got.first_job !== want.first_job ||
              got.last_job !== want.last_job || got.job_count !== want.job_count ||
              got.group_found !== want.group_found ||
              got.owner_rank !== want.owner_rank) begin
            err_count++;
            if (err_count <= 10) begin
              $display("error: mismatch at %0t (jobs %0d, workers %0d)", $realtime,
                       job_cfg, worker_cfg);
              $display("  expected valid %0b first %0d last %0d count %0d found %0b owner %0d",
                       want.range_valid, want.first_job, $signed(want.last_job),
                       want.job_count, want.group_found, want.owner_rank);
              $display("  actual   valid %0b first %0d last %0d count %0d found %0b owner %0d",
                       got.range_valid, got.first_job, $signed(got.last_job),
                       got.job_count, got.group_found, got.owner_rank);
            end
          end
        end
      end
      if (pat_idx == 5'd31) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom | $urandom;
          default: stall_pat = $urandom & $urandom;
        endcase
      end
      out_ready <= stall_pat[pat_idx];
      pat_idx <= pat_idx + 5'd1;
    end
  end

  task automatic add_query(bit [WW-1:0] rank, bit [JW-1:0] job);
    share_query_t q;
    q.rank = rank;
    q.job = job;
    query_q.insert(query_q.size(), q);
    queries_issued++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (queries_taken != queries_issued || share_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, bit [bjp_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == bjp_pkg::REG_JOB_TOTAL) job_cfg = value[JW-1:0];
    else worker_cfg = value[WW-1:0];
    // quotient rebuild keeps in_ready low for a while
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // upper data bits carry junk that the registers must drop
  task automatic apply_setup(bit [JW-1:0] jobs, bit [WW-1:0] workers);
    wait_drained();
    cfg_write(bjp_pkg::REG_JOB_TOTAL, 32'(jobs) | ($urandom << JW));
    cfg_write(bjp_pkg::REG_WORKER_TOTAL, 32'(workers) | ($urandom << WW));
  endtask

  function automatic bit [JW-1:0] pick_jobs();
    case ($urandom_range(0, 5))
      0: return JW'($urandom_range(0, 40));
      1: return JW'($urandom_range(0, 1000));
      2: return JW'($urandom);
      3: return JOB_MAX;
      4: return JW'($urandom_range(0, 65535));
      default: return JW'($urandom_range(0, 8));
    endcase
  endfunction

  function automatic bit [WW-1:0] pick_workers();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WW'(1);
      2, 3: return WW'($urandom_range(1, 64));
      4, 5: return WW'($urandom);
      6: return RANK_MAX;
      default: return WW'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic random_queries(int n);
    bit [63:0] quo, rem, split;
    bit [WW-1:0] rank;
    bit [JW-1:0] job;
    quo = 0;
    rem = 0;
    if (worker_cfg != 0) begin
      quo = 64'(job_cfg) / 64'(worker_cfg);
      rem = 64'(job_cfg) % 64'(worker_cfg);
    end
    split = rem * (quo + 64'd1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          rank = WW'($urandom);
          job = JW'($urandom);
        end
        2, 3: begin
          // edges: last ranks and the long/short worker boundary
          rank = WW'(64'(worker_cfg) + 64'($urandom_range(0, 2)) - 64'd1);
          job = JW'(split + 64'($urandom_range(0, 2)) - 64'd1);
        end
        4: begin
          rank = WW'(rem + 64'($urandom_range(0, 2)) - 64'd1);
          job = JW'(64'(job_cfg) + 64'($urandom_range(0, 2)) - 64'd1);
        end
        default: begin
          rank = WW'($urandom_range(0, 32'(worker_cfg)));
          job = JW'($urandom_range(0, 32'(job_cfg)));
        end
      endcase
      add_query(rank, job);
    end
  endtask

  initial begin
    int unsigned leftover;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no jobs, one worker with an empty range
    add_query(0, 0);
    add_query(RANK_MAX, JOB_MAX);
    add_query(1, 5);

    // uneven split, one long worker
    apply_setup(10, 3);
    add_query(0, 0);
    add_query(1, 3);
    add_query(2, 4);
    add_query(3, 9);
    add_query(0, 10);
    add_query(1, 7);

    // more workers than jobs
    apply_setup(2, 5);
    add_query(0, 1);
    add_query(1, 0);
    add_query(2, 2);
    add_query(4, 1);
    add_query(5, 2);

    // widest settings
    apply_setup(JOB_MAX, RANK_MAX);
    add_query(0, 0);
    add_query(254, JW'(JOB_MAX - 1));
    add_query(WW'(RANK_MAX - 1), JOB_MAX);
    add_query(RANK_MAX, 24'd16776960);

    // zero workers
    apply_setup(JOB_MAX, 0);
    add_query(0, 0);
    add_query(RANK_MAX, 5);

    // no jobs, many workers
    apply_setup(0, RANK_MAX);
    add_query(0, 0);
    add_query(WW'(RANK_MAX - 1), 0);

    for (int p = 0; p < 10; p++) begin
      apply_setup(pick_jobs(), pick_workers());
      random_queries(63);
    end

    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    leftover = share_due_q.size();
    if (leftover != 0) begin
      err_count += leftover;
      $display("error: %0d expected result words never arrived", leftover);
    end
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("error: timeout");
    $display("status: fail");
    $finish;
  end

endmodule
